FILE: src/ufe_pkg.sv
// Shared types, constants and helper functions of the disjoint-set engine.
package ufe_pkg;

  // Fixed widths of the request and result fields.
  localparam int ID_W   = 10;
  localparam int RANK_W = 4;
  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

  // Width of the shift counter of the id reduction unit.
  localparam int SH_W = 4;

  // Controller states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_FIND_START,
    ST_FIND_CHECK,
    ST_WALK,
    ST_COMP_START,
    ST_COMP,
    ST_FIND_DONE,
    ST_LINK,
    ST_BUMP,
    ST_OUT
  } ufe_state_e;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_REDUCE,
    OP_FIND_START,
    OP_FIND_CHECK,
    OP_WALK,
    OP_COMP_START,
    OP_COMP,
    OP_FIND_DONE,
    OP_LINK,
    OP_BUMP,
    OP_OUT_LOAD
  } ufe_op_e;

  // Status flags returned by the datapath.
  typedef struct packed {
    logic clr_last;
    logic red_last;
    logic rd_present;
    logic rd_parent_is_cur;
    logic rd_parent_is_root;
    logic second;
    logic mode_find;
    logic roots_equal;
    logic a_lower;
    logic bump_needed;
    logic out_free;
  } ufe_status_t;

  // Number of compare-and-subtract steps that reduce a 10-bit id modulo m.
  function automatic int red_steps(int m);
    int s;
    s = 0;
    for (int k = 0; k < ID_W; k++) begin
      if ((m << k) < (1 << ID_W)) s = k + 1;
    end
    return s;
  endfunction

endpackage

FILE: src/ufe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ufe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/ufe_ctrl.sv
// Controller state machine of the disjoint-set engine.
module ufe_ctrl import ufe_pkg::*; #(
  parameter int ELEMENT_COUNT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ufe_status_t status_i,
  output ufe_op_e     op_o
);

  localparam int RedSteps = red_steps(ELEMENT_COUNT);

  ufe_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath operation.
  always_comb begin
    state_d    = state_q;
    op_o       = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        op_o = OP_CLEAR;
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o    = OP_ACCEPT;
          state_d = (RedSteps > 0) ? ST_REDUCE : ST_FIND_START;
        end
      end
      ST_REDUCE: begin
        op_o = OP_REDUCE;
        if (status_i.red_last) state_d = ST_FIND_START;
      end
      ST_FIND_START: begin
        op_o    = OP_FIND_START;
        state_d = ST_FIND_CHECK;
      end
      ST_FIND_CHECK: begin
        op_o = OP_FIND_CHECK;
        if (!status_i.rd_present || status_i.rd_parent_is_cur) begin
          state_d = ST_FIND_DONE;
        end else begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        op_o = OP_WALK;
        if (status_i.rd_parent_is_cur) state_d = ST_COMP_START;
      end
      ST_COMP_START: begin
        op_o    = OP_COMP_START;
        state_d = ST_COMP;
      end
      ST_COMP: begin
        op_o = OP_COMP;
        if (status_i.rd_parent_is_root) state_d = ST_FIND_DONE;
      end
      ST_FIND_DONE: begin
        op_o = OP_FIND_DONE;
        if (status_i.second) begin
          state_d = ST_LINK;
        end else if (status_i.mode_find) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_FIND_START;
        end
      end
      ST_LINK: begin
        op_o = OP_LINK;
        if (!status_i.roots_equal && !status_i.a_lower && status_i.bump_needed) begin
          state_d = ST_BUMP;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_BUMP: begin
        op_o    = OP_BUMP;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        op_o = OP_OUT_LOAD;
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // A new request is taken only from the idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE)
    else $error("input ready outside idle");

  // The clearing pass is never re-entered once it has finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_CLEAR |=> state_q != ST_CLEAR)
    else $error("clearing pass re-entered");

  // A transfer on the input always leads out of idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != ST_IDLE)
    else $error("accepted request dropped");

endmodule

FILE: src/ufe_datapath.sv
// Datapath of the disjoint-set engine: element store, walk registers and result register.
module ufe_datapath import ufe_pkg::*; #(
  parameter int ELEMENT_COUNT = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ufe_op_e           op_i,
  output ufe_status_t       status_o,
  input  logic              mode_i,
  input  logic [ID_W-1:0]   first_id_i,
  input  logic [ID_W-1:0]   second_id_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ID_W-1:0]   root_id_o,
  output logic              merged_o
);

  localparam int IDX_W     = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;
  localparam int WORD_W    = 1 + RANK_W + IDX_W;
  localparam int RedSteps  = red_steps(ELEMENT_COUNT);
  localparam int RED_START = (RedSteps > 0) ? RedSteps - 1 : 0;
  localparam logic [ID_W:0]      MOD_V    = (ID_W + 1)'(ELEMENT_COUNT);
  localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(ELEMENT_COUNT - 1);

  // One store word per element: present bit, rank and parent link.
  typedef struct packed {
    logic              present;
    logic [RANK_W-1:0] rank;
    logic [IDX_W-1:0]  parent;
  } ufe_word_t;

  // Control registers.
  logic [IDX_W-1:0] clr_q;
  logic [SH_W-1:0]  sh_q;
  logic             second_q;
  logic             out_valid_q;

  // Request and walk registers.
  logic              mode_q;
  logic [ID_W-1:0]   a_q, b_q;
  logic [IDX_W-1:0]  node_q, cur_q, root_q, ra_q;
  logic [RANK_W-1:0] rank_q, rank_a_q;
  logic [IDX_W-1:0]  res_root_q;
  logic              res_merged_q;
  logic [ID_W-1:0]   out_root_q;
  logic              out_merged_q;

  // Store port signals.
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  ufe_word_t        ram_wdata, rd;
  logic [WORD_W-1:0] ram_rdata;

  logic [ID_W:0]    mod_shift;
  logic [IDX_W-1:0] node_sel;
  logic             out_free;

  assign rd        = ufe_word_t'(ram_rdata);
  assign mod_shift = MOD_V << sh_q;
  assign node_sel  = second_q ? IDX_W'(b_q) : IDX_W'(a_q);
  assign out_free  = !out_valid_q || out_ready_i;

  ufe_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ELEMENT_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (WORD_W'(ram_wdata)),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Store accesses for each operation.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = rd.parent;
    case (op_i)
      OP_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
      end
      OP_FIND_START: begin
        ram_re    = 1'b1;
        ram_raddr = node_sel;
      end
      OP_FIND_CHECK: begin
        if (!rd.present) begin
          ram_we    = 1'b1;
          ram_waddr = node_q;
          ram_wdata = '{present: 1'b1, rank: '0, parent: node_q};
        end else if (rd.parent != cur_q) begin
          ram_re = 1'b1;
        end
      end
      OP_WALK: begin
        ram_re = (rd.parent != cur_q);
      end
      OP_COMP_START: begin
        ram_re    = 1'b1;
        ram_raddr = node_q;
      end
      OP_COMP: begin
        // Point the walked node straight at the root, then fetch the next one.
        ram_we    = 1'b1;
        ram_waddr = cur_q;
        ram_wdata = '{present: 1'b1, rank: rd.rank, parent: root_q};
        ram_re    = (rd.parent != root_q);
      end
      OP_LINK: begin
        if (ra_q != root_q) begin
          ram_we = 1'b1;
          if (rank_a_q < rank_q) begin
            ram_waddr = ra_q;
            ram_wdata = '{present: 1'b1, rank: rank_a_q, parent: root_q};
          end else begin
            ram_waddr = root_q;
            ram_wdata = '{present: 1'b1, rank: rank_q, parent: ra_q};
          end
        end
      end
      OP_BUMP: begin
        ram_we    = 1'b1;
        ram_waddr = ra_q;
        ram_wdata = '{present: 1'b1, rank: rank_a_q + RANK_W'(1), parent: ra_q};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      sh_q        <= '0;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (op_i == OP_CLEAR) clr_q <= clr_q + IDX_W'(1);
      if (op_i == OP_ACCEPT) begin
        sh_q     <= SH_W'(RED_START);
        second_q <= 1'b0;
      end
      if (op_i == OP_REDUCE && sh_q != '0) sh_q <= sh_q - SH_W'(1);
      if (op_i == OP_FIND_DONE) second_q <= 1'b1;
      // Result register: load on completion, clear on output transfer.
      if (op_i == OP_OUT_LOAD && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request, walk and result registers.
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_ACCEPT: begin
        mode_q <= mode_i;
        a_q    <= first_id_i;
        b_q    <= second_id_i;
      end
      OP_REDUCE: begin
        // One restoring step of the modulo reduction for both ids.
        if ({1'b0, a_q} >= mod_shift) a_q <= ID_W'({1'b0, a_q} - mod_shift);
        if ({1'b0, b_q} >= mod_shift) b_q <= ID_W'({1'b0, b_q} - mod_shift);
      end
      OP_FIND_START: begin
        node_q <= node_sel;
        cur_q  <= node_sel;
      end
      OP_FIND_CHECK: begin
        if (!rd.present) begin
          root_q <= node_q;
          rank_q <= '0;
        end else if (rd.parent == cur_q) begin
          root_q <= cur_q;
          rank_q <= rd.rank;
        end else begin
          cur_q <= rd.parent;
        end
      end
      OP_WALK: begin
        if (rd.parent == cur_q) begin
          root_q <= cur_q;
          rank_q <= rd.rank;
        end else begin
          cur_q <= rd.parent;
        end
      end
      OP_COMP_START: begin
        cur_q <= node_q;
      end
      OP_COMP: begin
        cur_q <= rd.parent;
      end
      OP_FIND_DONE: begin
        if (!second_q) begin
          ra_q         <= root_q;
          rank_a_q     <= rank_q;
          res_root_q   <= root_q;
          res_merged_q <= 1'b0;
        end
      end
      OP_LINK: begin
        if (ra_q == root_q) begin
          res_root_q   <= ra_q;
          res_merged_q <= 1'b0;
        end else if (rank_a_q < rank_q) begin
          res_root_q   <= root_q;
          res_merged_q <= 1'b1;
        end else begin
          res_root_q   <= ra_q;
          res_merged_q <= 1'b1;
        end
      end
      OP_OUT_LOAD: begin
        if (out_free) begin
          out_root_q   <= ID_W'(res_root_q);
          out_merged_q <= res_merged_q;
        end
      end
      default: begin
        mode_q <= mode_q;
      end
    endcase
  end

  // Status toward the controller.
  always_comb begin
    status_o.clr_last          = (clr_q == IDX_LAST);
    status_o.red_last          = (sh_q == '0);
    status_o.rd_present        = rd.present;
    status_o.rd_parent_is_cur  = (rd.parent == cur_q);
    status_o.rd_parent_is_root = (rd.parent == root_q);
    status_o.second            = second_q;
    status_o.mode_find         = mode_q;
    status_o.roots_equal       = (ra_q == root_q);
    status_o.a_lower           = (rank_a_q < rank_q);
    status_o.bump_needed       = (rank_a_q == rank_q) && (rank_a_q != RANK_MAX);
    status_o.out_free          = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign root_id_o   = out_root_q;
  assign merged_o    = out_merged_q;

  // A read never targets the entry written in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("store read and write collide");

  // Path compression never rewrites the root itself.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == OP_COMP |-> cur_q != root_q)
    else $error("compression reached the root");

  // A find request never reports a merge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == OP_FIND_DONE && !second_q && mode_q |=> !res_merged_q)
    else $error("find reported a merge");

  // A completed request is presented on the output in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == OP_OUT_LOAD && out_free |=> out_valid_q)
    else $error("result not presented");

endmodule

FILE: src/union_find_engine.sv
// Top level of the disjoint-set engine: controller plus datapath.
//
// Disjoint-set engine with union by rank and path compression over
// ELEMENT_COUNT elements, one request at a time. After reset the element
// store is cleared in a pass over every element, during which no request
// is taken. A find of an element that is new or already a root needs no
// walk. When the element is not a root, each link on its path is walked
// once and then compressed, and the walk restarts at the element before
// compression begins; every step is one read of the element store. A
// union of two elements finds both roots and links them, with one more
// step when the ranks are equal and the surviving rank must grow. When
// ELEMENT_COUNT is below 1024 the ids are first reduced modulo
// ELEMENT_COUNT, one restoring step a cycle. The result register lets the
// next request be taken while an earlier result waits for its transfer.
module union_find_engine import ufe_pkg::*; #(
  parameter int ELEMENT_COUNT = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            mode_i,
  input  logic [ID_W-1:0] first_id_i,
  input  logic [ID_W-1:0] second_id_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [ID_W-1:0] root_id_o,
  output logic            merged_o
);

  ufe_op_e     op;
  ufe_status_t status;

  ufe_ctrl #(
    .ELEMENT_COUNT (ELEMENT_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .op_o       (op)
  );

  ufe_datapath #(
    .ELEMENT_COUNT (ELEMENT_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .status_o    (status),
    .mode_i      (mode_i),
    .first_id_i  (first_id_i),
    .second_id_i (second_id_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .root_id_o   (root_id_o),
    .merged_o    (merged_o)
  );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the disjoint-set engine with union by rank and path compression.
`timescale 1ns / 100ps

module testbench;
  import ufe_pkg::*;

  localparam int ELEMS = 1024;
  localparam int RANDOM_ITEMS = 1734;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 64;

  // Request codes of the mode field.
  localparam logic MODE_UNION = 1'b0;
  localparam logic MODE_FIND = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0] root;
    logic            merged;
  } set_result_t;

  typedef struct packed {
    logic            mode;
    logic [ID_W-1:0] first;
    logic [ID_W-1:0] second;
    logic            known;
    logic [ID_W-1:0] root;
    logic            merged;
  } dir_row_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic            req_mode = MODE_FIND;
  logic [ID_W-1:0] req_first = '0;
  logic [ID_W-1:0] req_second = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [ID_W-1:0] root_id;
  logic            merged;

  // Typed expectation that travels with a directed request.
  logic            typed_known = 1'b0;
  set_result_t     typed_result = '0;

  // Shadow forest kept by the predictor.
  bit              seen [ELEMS];
  logic [ID_W-1:0] up_link [ELEMS];
  logic [RANK_W-1:0] set_rank [ELEMS];

  set_result_t     pending_roots [$];
  dir_row_t        dir_rows [$];
  int              mismatches = 0;
  int              cycles = 0;
  int              hold_left = 0;
  bit              steady = 1'b0;

  union_find_engine #(.ELEMENT_COUNT(ELEMS)) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .mode_i      (req_mode),
    .first_id_i  (req_first),
    .second_id_i (req_second),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .root_id_o   (root_id),
    .merged_o    (merged)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Follow links to the root, then point every node on the path at it.
  function automatic logic [ID_W-1:0] locate_root(input logic [ID_W-1:0] node);
    logic [ID_W-1:0] top;
    logic [ID_W-1:0] cur;
    logic [ID_W-1:0] nxt;
    if (!seen[node]) begin
      seen[node] = 1'b1;
      up_link[node] = node;
      set_rank[node] = '0;
      return node;
    end
    top = node;
    while (up_link[top] != top) top = up_link[top];
    cur = node;
    while (cur != top) begin
      nxt = up_link[cur];
      up_link[cur] = top;
      cur = nxt;
    end
    return top;
  endfunction

  // Apply one request to the shadow forest and return the result it causes.
  function automatic set_result_t apply_request(input logic m, input logic [ID_W-1:0] a,
                                                input logic [ID_W-1:0] b);
    logic [ID_W-1:0] ra;
    logic [ID_W-1:0] rb;
    set_result_t res;
    res = '0;
    ra = locate_root(ID_W'(a % ELEMS));
    res.root = ra;
    if (m == MODE_UNION) begin
      rb = locate_root(ID_W'(b % ELEMS));
      if (ra != rb) begin
        res.merged = 1'b1;
        if (set_rank[ra] < set_rank[rb]) begin
          up_link[ra] = rb;
          res.root = rb;
        end else begin
          if (set_rank[ra] == set_rank[rb] && set_rank[ra] < RANK_MAX)
            set_rank[ra] = set_rank[ra] + 1'b1;
          up_link[rb] = ra;
        end
      end
    end
    return res;
  endfunction

  function automatic dir_row_t dir_row(input logic m, input int a, input int b,
                                       input logic known, input int r, input logic mg);
    dir_row_t row;
    row.mode = m;
    row.first = ID_W'(a);
    row.second = ID_W'(b);
    row.known = known;
    row.root = ID_W'(r);
    row.merged = mg;
    return row;
  endfunction

  // Mostly short idle stretches, now and then a long one.
  function automatic int stall_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one request and hold it until the transfer; returns at a falling edge.
  task automatic send_req(input logic m, input logic [ID_W-1:0] a, input logic [ID_W-1:0] b,
                          input logic known, input set_result_t typed);
    int gap;
    gap = (steady || $urandom_range(0, 99) < 55) ? 0 : stall_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_mode <= m;
    req_first <= a;
    req_second <= b;
    typed_known <= known;
    typed_result <= typed;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  task automatic send_rand(input logic m, input logic [ID_W-1:0] a, input logic [ID_W-1:0] b);
    send_req(m, a, b, 1'b0, '0);
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver side: random back-pressure with steady stretches.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 99) < 25) begin
      hold_left <= stall_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check each result transfer, then predict for each request transfer.
  always @(posedge clk) begin : result_check
    set_result_t want;
    set_result_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_roots.size() == 0) begin
          $display("%0t: result with nothing expected: root_id %0d merged %0d",
                   $realtime, root_id, merged);
          mismatches++;
        end else begin
          want = pending_roots.pop_front();
          if (root_id !== want.root) begin
            $display("%0t: root_id expected %0d actual %0d", $realtime, want.root, root_id);
            mismatches++;
          end
          if (merged !== want.merged) begin
            $display("%0t: merged expected %0d actual %0d", $realtime, want.merged, merged);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        got = apply_request(req_mode, req_first, req_second);
        pending_roots.push_back(typed_known ? typed_result : got);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int sent;
    int kind;
    int k;
    int sz;
    int base;
    int n;
    bit paused;
    logic [ID_W-1:0] a;
    logic [ID_W-1:0] b;
    set_result_t typed;

    sent = 0;
    paused = 1'b0;

    // Directed requests: new elements, extremes, self unions, rank ordering, compression.
    dir_rows.push_back(dir_row(MODE_FIND, 0, 0, 1'b1, 0, 1'b0));
    dir_rows.push_back(dir_row(MODE_FIND, 1023, 0, 1'b1, 1023, 1'b0));
    dir_rows.push_back(dir_row(MODE_UNION, 0, 1023, 1'b1, 0, 1'b1));
    dir_rows.push_back(dir_row(MODE_UNION, 1023, 0, 1'b1, 0, 1'b0));
    dir_rows.push_back(dir_row(MODE_UNION, 5, 5, 1'b1, 5, 1'b0));
    dir_rows.push_back(dir_row(MODE_UNION, 6, 7, 1'b1, 6, 1'b1));
    dir_rows.push_back(dir_row(MODE_UNION, 7, 0, 1'b0, 0, 1'b0));
    dir_rows.push_back(dir_row(MODE_FIND, 1023, 1023, 1'b0, 0, 1'b0));
    dir_rows.push_back(dir_row(MODE_UNION, 8, 6, 1'b0, 0, 1'b0));
    dir_rows.push_back(dir_row(MODE_UNION, 9, 10, 1'b1, 9, 1'b1));
    dir_rows.push_back(dir_row(MODE_UNION, 9, 7, 1'b0, 0, 1'b0));
    dir_rows.push_back(dir_row(MODE_FIND, 10, 0, 1'b0, 0, 1'b0));
    dir_rows.push_back(dir_row(MODE_UNION, 682, 341, 1'b1, 682, 1'b1));
    dir_rows.push_back(dir_row(MODE_FIND, 341, 682, 1'b0, 0, 1'b0));
    dir_rows.push_back(dir_row(MODE_UNION, 1023, 1023, 1'b0, 0, 1'b0));
    dir_rows.push_back(dir_row(MODE_FIND, 1022, 0, 1'b1, 1022, 1'b0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      typed.root = dir_rows[i].root;
      typed.merged = dir_rows[i].merged;
      send_req(dir_rows[i].mode, dir_rows[i].first, dir_rows[i].second, dir_rows[i].known,
               typed);
    end
    drain();

    // Random part: tree builds, small-pool bursts and full-range noise.
    while (sent < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 9) == 0);
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        drain();
      end
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        // Pairwise merges of equal-rank roots build deep trees, then finds walk them.
        k = $urandom_range(1, 5);
        sz = 1 << k;
        base = $urandom_range(0, ELEMS / 32 - 1) * 32;
        for (int s = 1; s < sz; s = s * 2) begin
          for (int i = 0; i < sz; i = i + 2 * s) begin
            a = ID_W'(base + i);
            b = ID_W'(base + i + s);
            if ($urandom_range(0, 1)) send_rand(MODE_UNION, a, b);
            else send_rand(MODE_UNION, b, a);
            sent++;
          end
        end
        n = $urandom_range(2, 6);
        repeat (n) begin
          send_rand(MODE_FIND, ID_W'(base + $urandom_range(0, sz - 1)),
                    ID_W'($urandom_range(0, ELEMS - 1)));
          sent++;
        end
      end else if (kind < 55) begin
        // Mixed requests within a small pool, so sets meet often.
        base = $urandom_range(0, ELEMS / 16 - 1) * 16;
        repeat (8) begin
          send_rand(logic'($urandom_range(0, 1)), ID_W'(base + $urandom_range(0, 15)),
                    ID_W'(base + $urandom_range(0, 15)));
          sent++;
        end
      end else begin
        send_rand(logic'($urandom_range(0, 1)), ID_W'($urandom_range(0, ELEMS - 1)),
                  ID_W'($urandom_range(0, ELEMS - 1)));
        sent++;
      end
    end

    // Let everything outstanding come back, then a short tail.
    steady = 1'b0;
    in_valid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_roots.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/ufe_pkg.sv
src/ufe_ram.sv
src/ufe_ctrl.sv
src/ufe_datapath.sv
src/union_find_engine.sv
tb/testbench.sv
